// ===== hw/rtl/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared constants, types and the CRC-16/MODBUS byte step for the status
// frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

  localparam int FRAME_LEN  = 15;
  localparam int CRC_SPAN   = 10;   // frame bytes 2..11
  localparam int BODY_BYTES = 8;    // frame bytes 2..9, the rest of the span is zero
  localparam int IN_W       = 56;

  localparam int          CNT_W      = $clog2(FRAME_LEN);
  localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(FRAME_LEN - 1);

  localparam logic [7:0]  SYNC_A   = 8'hA3;
  localparam logic [7:0]  SYNC_B   = 8'hB3;
  localparam logic [7:0]  END_MARK = 8'hC3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // body[0] type, [1] seq, [2] flags, [3] mode, [4] pitch hi, [5] pitch lo,
  // [6] ack seq, [7] fault
  typedef struct packed {
    logic [BODY_BYTES-1:0][7:0] body;
    logic [15:0]                crc;
  } sfb_stage_t;

  // one byte through the reflected CRC, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  din);
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, din};
    for (int b = 0; b < 8; b++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/status_frame_builder_crc16.sv =====
// ----------------------------------------------------------------------------
// status_frame_builder_crc16
// Turns one status report into a 15-byte frame with a CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
// Each report accepted on the in_ channel comes out as a 15-byte frame on the
// out_ channel, one byte per transfer, out_tlast on the last byte. The output
// is one byte wide, so the sending of frames sets the sustained rate. A report
// passes the CRC stages and the serialiser register before its first byte goes
// out. The CRC runs through a ten-stage pipeline, one frame byte per stage,
// so up to ten further reports are taken while a frame is being sent. The
// type byte is sampled from the configuration register when a report is taken.
module status_frame_builder_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // frame_type_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  // seq_number[7:0], status_flags[15:8], mode_byte[23:16],
  // pitch_centideg[39:24], ack_seq[47:40], fault_byte[55:48]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,       // out_byte[7:0]
  output logic        out_tlast        // last_byte
);
  import sfb_pkg::*;

  localparam int NSTG = CRC_SPAN;

  logic [7:0]               cfg_type_r;
  sfb_stage_t               stg_r   [NSTG];
  sfb_stage_t               stg_nxt [NSTG];
  logic [NSTG-1:0]          stg_v_r;
  logic [NSTG:0]            free;

  sfb_stage_t               ser_r;
  logic                     ser_v_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     ser_take;
  logic [15:0][7:0]         frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_type_r <= 8'h00;
    end else if (cfg_wr_en) begin
      cfg_type_r <= cfg_wr_data;
    end
  end

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    free[NSTG] = ser_take;
    for (int k = NSTG - 1; k >= 0; k--) begin
      free[k] = !stg_v_r[k] || free[k+1];
    end
  end

  assign in_tready = free[0];

  // stage 0 captures the report and runs the type byte through the CRC
  always_comb begin
    stg_nxt[0].body[0] = cfg_type_r;
    stg_nxt[0].body[1] = in_tdata[7:0];
    stg_nxt[0].body[2] = in_tdata[15:8];
    stg_nxt[0].body[3] = in_tdata[23:16];
    stg_nxt[0].body[4] = in_tdata[39:32];
    stg_nxt[0].body[5] = in_tdata[31:24];
    stg_nxt[0].body[6] = in_tdata[47:40];
    stg_nxt[0].body[7] = in_tdata[55:48];
    stg_nxt[0].crc     = crc_byte(CRC_INIT, cfg_type_r);
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_crc
    always_comb begin
      stg_nxt[k].body = stg_r[k-1].body;
      if (k < BODY_BYTES) begin
        stg_nxt[k].crc = crc_byte(stg_r[k-1].crc, stg_r[k-1].body[k % BODY_BYTES]);
      end else begin
        stg_nxt[k].crc = crc_byte(stg_r[k-1].crc, 8'h00);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (free[k]) begin
          stg_v_r[k] <= (k == 0) ? in_tvalid : stg_v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (free[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // serialiser: one finished frame, sent a byte per transfer
  assign ser_take = !ser_v_r || (out_tready && (cnt_r == FRAME_LAST));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r   <= '0;
    end else if (ser_take) begin
      ser_v_r <= stg_v_r[NSTG-1];
      cnt_r   <= '0;
    end else if (out_tready) begin
      cnt_r   <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_r <= stg_r[NSTG-1];
    end
  end

  always_comb begin
    frame     = '0;
    frame[0]  = SYNC_A;
    frame[1]  = SYNC_B;
    for (int j = 0; j < BODY_BYTES; j++) begin
      frame[2+j] = ser_r.body[j];
    end
    frame[12] = ser_r.crc[7:0];
    frame[13] = ser_r.crc[15:8];
    frame[14] = END_MARK;
  end

  assign out_tvalid = ser_v_r;
  assign out_tdata  = frame[cnt_r];
  assign out_tlast  = (cnt_r == FRAME_LAST);

endmodule

// ===== hw/rtl/sfb_checker.sv =====
// ----------------------------------------------------------------------------
// sfb_checker
// Port-level checks on the frame builder's output stream.
// ----------------------------------------------------------------------------
module sfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);
  import sfb_pkg::*;

  logic             out_xfer;
  logic [CNT_W-1:0] pos_r;

  assign out_xfer = out_tvalid && out_tready;

  // position of the next byte within its frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (out_xfer) begin
      pos_r <= (pos_r == FRAME_LAST) ? '0 : pos_r + CNT_W'(1);
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transfer changed");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (out_tlast == (pos_r == FRAME_LAST)))
    else $error("tlast not on the fifteenth byte");

  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && (pos_r == '0) |-> (out_tdata == SYNC_A))
    else $error("frame does not open with the sync byte");

  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_tlast |-> (out_tdata == END_MARK))
    else $error("frame does not close with the end byte");

endmodule

bind status_frame_builder_crc16 sfb_checker u_sfb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for status_frame_builder_crc16. Status reports go in on
// the in_ stream. Each accepted report is turned into its 15-byte frame,
// CRC-16/MODBUS included, and the bytes are queued. Every byte on the out_
// stream is checked against the oldest queued byte and its tlast flag. The run
// goes through several type byte settings and random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import sfb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEMS_PER_PH = 30;
  localparam int N_DIRECTED   = 15;
  localparam int TAIL_CYCLES  = 30;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // in_tdata layout, high to low: fault, ack, pitch[15:0], mode, flags, seq.
  // Pitch bytes are typed in where the big-endian split is plain to see.
  typedef struct packed {
    logic [55:0] report;
    logic        pitch_known;
    logic [7:0]  pitch_hi;
    logic [7:0]  pitch_lo;
  } directed_row_t;

  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{56'h00_00_0000_00_00_00, 1'b1, 8'h00, 8'h00},
    '{56'hFF_FF_FFFF_FF_FF_FF, 1'b1, 8'hFF, 8'hFF},
    '{56'h00_00_0000_00_00_FF, 1'b1, 8'h00, 8'h00},
    '{56'h00_00_0000_00_FF_00, 1'b1, 8'h00, 8'h00},
    '{56'h00_00_0000_FF_00_00, 1'b1, 8'h00, 8'h00},
    '{56'h00_00_1234_00_00_00, 1'b1, 8'h12, 8'h34},
    '{56'h00_00_FF00_00_00_00, 1'b1, 8'hFF, 8'h00},
    '{56'h00_00_00FF_00_00_00, 1'b1, 8'h00, 8'hFF},
    '{56'h00_FF_0000_00_00_00, 1'b0, 8'h00, 8'h00},
    '{56'hFF_00_0000_00_00_00, 1'b0, 8'h00, 8'h00},
    '{56'hAA_55_AA55_AA_55_AA, 1'b1, 8'hAA, 8'h55},
    '{56'h55_AA_55AA_55_AA_55, 1'b1, 8'h55, 8'hAA},
    '{56'h00_00_8001_00_00_00, 1'b1, 8'h80, 8'h01},
    '{56'h01_02_0304_05_06_07, 1'b1, 8'h03, 8'h04},
    '{56'h80_80_8080_80_80_80, 1'b1, 8'h80, 8'h80}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  frame_byte_t frame_bytes_q [$];
  frame_byte_t want;
  logic [7:0]  type_byte_shadow;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          bad_count = 0;
  int          cycles = 0;

  status_frame_builder_crc16 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // frame for one report; CRC runs over bytes 2..11, LSB first
  function automatic frame_t build_status_frame(input logic [7:0]  ty,
                                                input logic [55:0] rep);
    frame_t      fr;
    logic [15:0] acc;
    fr[0]  = SYNC_A;
    fr[1]  = SYNC_B;
    fr[2]  = ty;
    fr[3]  = rep[7:0];
    fr[4]  = rep[15:8];
    fr[5]  = rep[23:16];
    fr[6]  = rep[39:32];
    fr[7]  = rep[31:24];
    fr[8]  = rep[47:40];
    fr[9]  = rep[55:48];
    fr[10] = 8'h00;
    fr[11] = 8'h00;
    acc = CRC_INIT;
    for (int k = 2; k < 2 + CRC_SPAN; k++) begin
      acc = acc ^ {8'h00, fr[k]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    fr[12] = acc[7:0];
    fr[13] = acc[15:8];
    fr[14] = END_MARK;
    return fr;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_report(input logic [55:0] rep, input logic pitch_known,
                             input logic [7:0] hi, input logic [7:0] lo);
    frame_t      fr;
    frame_byte_t fb;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rep;
    do @(posedge clk); while (!in_tready);
    fr = build_status_frame(type_byte_shadow, rep);
    if (pitch_known) begin
      fr[6] = hi;
      fr[7] = lo;
    end
    for (int k = 0; k < FRAME_LEN; k++) begin
      fb.data = fr[k];
      fb.last = (k == FRAME_LEN - 1);
      frame_bytes_q.push_back(fb);
    end
    @(negedge clk);
  endtask

  task automatic drain_frames();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (frame_bytes_q.size() != 0);
  endtask

  task automatic write_type_byte(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    type_byte_shadow = v;
  endtask

  always @(negedge clk) begin
    out_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_bytes_q.size() == 0) begin
        if (bad_count < 10)
          $display("unexpected byte: data=%h last=%b", out_tdata, out_tlast);
        bad_count++;
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_tdata !== want.data || out_tlast !== want.last) begin
          if (bad_count < 10)
            $display("byte mismatch: want data=%h last=%b, got data=%h last=%b",
                     want.data, want.last, out_tdata, out_tlast);
          bad_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [63:0] rnd;
    logic [55:0] rep;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 8'h00;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    type_byte_shadow = 8'h00;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // type byte still at its reset value here
    for (int r = 0; r < N_DIRECTED; r++)
      send_report(DIRECTED[r].report, DIRECTED[r].pitch_known,
                  DIRECTED[r].pitch_hi, DIRECTED[r].pitch_lo);

    for (int ph = 0; ph < 4; ph++) begin
      drain_frames();
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_type_byte(8'hFF);
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
          write_type_byte(8'($urandom));
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
          write_type_byte(8'h00);
        end
        default: begin
          send_idle_pct  = 22;
          recv_stall_pct = 22;
          write_type_byte(8'($urandom));
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PH; i++) begin
        // hold off until the block has sent everything
        if (ph == 1 && i == ITEMS_PER_PH / 2)
          drain_frames();
        rnd = {$urandom, $urandom};
        case ($urandom_range(9))
          0:       rep = '0;
          1:       rep = '1;
          default: rep = rnd[55:0];
        endcase
        send_report(rep, 1'b0, 8'h00, 8'h00);
      end
    end

    drain_frames();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_count == 0 && frame_bytes_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sfb_pkg.sv
hw/rtl/status_frame_builder_crc16.sv
hw/rtl/sfb_checker.sv
tb/tb_top.sv
